@@ rtl/ilist_pkg.sv @@
// Shared types and constants for the indexed list insert/remove unit.
// Used by the controller, datapath, top level and checker; no dependencies.
package ilist_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int ELEM_W_DEF   = 32;

	localparam int KIND_W  = 2;
	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 5;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_WRITE  = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic err;
		logic no_read;
		logic rd_last;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/indexed_list_insert_remove_unit.sv @@
// Indexed list insert/remove unit: one word in, one result word out.
// Errors and inserts at the end skip the walk and go straight to the result register;
// read and write read one entry; insert and remove walk the entry store one entry per cycle,
// shifting the entries from the end down to the position, or those above it down by one.
// A new word is taken the cycle after its predecessor's result is registered.
// Reset clears the live count and control; store contents stay undefined, no clearing pass.
module indexed_list_insert_remove_unit #(
	parameter int CAPACITY      = ilist_pkg::CAPACITY_DEF,
	parameter int ELEMENT_WIDTH = ilist_pkg::ELEM_W_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [ilist_pkg::IN_DATA_W-1:0]       s_tdata,  // position[4:0], value[36:5]
	input  logic [ilist_pkg::KIND_W-1:0]          s_tuser,  // kind[1:0]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [ilist_pkg::OUT_DATA_W-1:0]      m_tdata,  // result_value[31:0], count[36:32]
	output logic [ilist_pkg::STAT_W-1:0]          m_tuser   // status[1:0]
);

	ilist_pkg::cmd_t  cmd;
	ilist_pkg::stat_t stat;
	logic signed [ilist_pkg::VAL_W-1:0] result_value;
	logic [ilist_pkg::CNT_W-1:0]        count;

	ilist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ilist_datapath #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_kind      (ilist_pkg::kind_t'(s_tuser)),
		.in_position  (s_tdata[4:0]),
		.in_value     ($signed(s_tdata[36:5])),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.result_value (result_value),
		.status       (m_tuser),
		.count        (count)
	);

	assign m_tdata = {3'b000, count, result_value};

endmodule

@@ rtl/ilist_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents are undefined until written.
module ilist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/ilist_ctrl.sv @@
// Controller state machine for the indexed list unit.
// Depends on ilist_pkg for the command and status structs.
module ilist_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  ilist_pkg::stat_t   stat,
	output ilist_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FINAL = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.step   = (state_q == ST_SCAN) && !stat.err && !stat.no_read;
	assign cmd.commit = (state_q == ST_FINAL) && stat.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.err || stat.no_read) state_d = ST_FINAL;
				else if (stat.rd_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last read data lands this cycle
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/ilist_datapath.sv @@
// Datapath for the indexed list unit: entry store, live count, shift walker,
// result register. Depends on ilist_pkg and ilist_ram.
module ilist_datapath #(
	parameter int CAPACITY      = ilist_pkg::CAPACITY_DEF,
	parameter int ELEMENT_WIDTH = ilist_pkg::ELEM_W_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ilist_pkg::kind_t                    in_kind,
	input  logic        [ilist_pkg::POS_W-1:0]  in_position,
	input  logic signed [ilist_pkg::VAL_W-1:0]  in_value,
	input  ilist_pkg::cmd_t                     cmd,
	output ilist_pkg::stat_t                    stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ilist_pkg::VAL_W-1:0]  result_value,
	output logic        [ilist_pkg::STAT_W-1:0] status,
	output logic        [ilist_pkg::CNT_W-1:0]  count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > ilist_pkg::POS_W) ? CW : ilist_pkg::POS_W;
	localparam int OW = (XW > ilist_pkg::CNT_W) ? XW : ilist_pkg::CNT_W;

	ilist_pkg::kind_t     kind_q;
	ilist_pkg::status_t   stat_q, stat_d;
	logic [AW-1:0]        pos_q;
	logic [ELEMENT_WIDTH-1:0] elem_q, elem_in;
	logic [CW-1:0]        cnt_q, cnt_new, cnt_m1;
	logic [AW-1:0]        rd_idx_q;
	logic                 no_read_q;
	logic                 pend_q, pend_wr_q, pend_old_q;
	logic [AW-1:0]        pend_addr_q;
	logic [ELEMENT_WIDTH-1:0] old_q, rdata;
	logic                 out_valid_q;
	logic [ilist_pkg::VAL_W-1:0] out_val_q;
	logic [ilist_pkg::STAT_W-1:0] out_stat_q;
	logic [ilist_pkg::CNT_W-1:0]  out_cnt_q;
	logic [XW-1:0]        pos_x, cnt_x;
	logic [OW-1:0]        cnt_new_x;
	logic                 ok_q, we;
	logic [AW-1:0]        waddr;
	logic [ELEMENT_WIDTH-1:0] wdata;

	assign pos_x   = XW'(in_position);
	assign cnt_x   = XW'(cnt_q);
	assign cnt_m1  = cnt_q - 1'b1;
	assign elem_in = ELEMENT_WIDTH'(in_value);
	assign ok_q    = (stat_q == ilist_pkg::STAT_OK);

	always_comb begin
		stat_d = ilist_pkg::STAT_OK;
		if (in_kind == ilist_pkg::KIND_INSERT) begin
			// position check takes priority over fullness
			if (pos_x > cnt_x) stat_d = ilist_pkg::STAT_BAD_INDEX;
			else if (cnt_x >= XW'(CAPACITY)) stat_d = ilist_pkg::STAT_FULL;
		end else if (pos_x >= cnt_x) begin
			stat_d = ilist_pkg::STAT_BAD_INDEX;
		end
	end

	always_comb begin
		cnt_new = cnt_q;
		if (ok_q && kind_q == ilist_pkg::KIND_INSERT) cnt_new = cnt_q + 1'b1;
		else if (ok_q && kind_q == ilist_pkg::KIND_REMOVE) cnt_new = cnt_m1;
	end
	assign cnt_new_x = OW'(cnt_new);

	assign stat.err      = !ok_q;
	assign stat.no_read  = no_read_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.rd_last  = (kind_q == ilist_pkg::KIND_INSERT) ? (rd_idx_q == pos_q) :
		(kind_q == ilist_pkg::KIND_REMOVE) ? (rd_idx_q == cnt_m1[AW-1:0]) : 1'b1;

	// store write: shifted word from the walker, or the new element at commit
	always_comb begin
		we    = 1'b0;
		waddr = pend_addr_q;
		wdata = rdata;
		if (pend_q && pend_wr_q) begin
			we = 1'b1;
		end else if (cmd.commit && ok_q &&
			(kind_q inside {ilist_pkg::KIND_INSERT, ilist_pkg::KIND_WRITE})) begin
			we    = 1'b1;
			waddr = pos_q;
			wdata = elem_q;
		end
	end

	ilist_ram #(
		.WIDTH(ELEMENT_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= in_kind;
			pos_q     <= pos_x[AW-1:0];
			elem_q    <= elem_in;
			no_read_q <= (in_kind == ilist_pkg::KIND_INSERT) && (pos_x == cnt_x);
			if (in_kind == ilist_pkg::KIND_INSERT) rd_idx_q <= cnt_m1[AW-1:0];
			else rd_idx_q <= pos_x[AW-1:0];
		end else if (cmd.step) begin
			if (kind_q == ilist_pkg::KIND_INSERT) rd_idx_q <= rd_idx_q - 1'b1;
			else rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (cmd.step) begin
			pend_wr_q  <= (kind_q == ilist_pkg::KIND_INSERT) ||
				(kind_q == ilist_pkg::KIND_REMOVE && rd_idx_q != pos_q);
			pend_old_q <= (kind_q != ilist_pkg::KIND_INSERT) && (rd_idx_q == pos_q);
			if (kind_q == ilist_pkg::KIND_INSERT) pend_addr_q <= rd_idx_q + 1'b1;
			else pend_addr_q <= rd_idx_q - 1'b1;
		end
		if (pend_q && pend_old_q) begin
			old_q <= rdata;
		end
		if (cmd.commit) begin
			out_stat_q <= stat_q;
			out_cnt_q  <= cnt_new_x[ilist_pkg::CNT_W-1:0];
			if (ok_q && kind_q != ilist_pkg::KIND_INSERT) out_val_q <= 32'($signed(old_q));
			else out_val_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			stat_q      <= ilist_pkg::STAT_OK;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.step;
			if (cmd.load) stat_q <= stat_d;
			if (cmd.commit) begin
				cnt_q       <= cnt_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_val_q;
	assign status       = out_stat_q;
	assign count        = out_cnt_q;

endmodule

@@ rtl/ilist_checker.sv @@
// Port-level checker for the indexed list unit, bound to the top level.
// Depends on ilist_pkg for kind and status codes.
module ilist_port_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [ilist_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic [ilist_pkg::KIND_W-1:0]     s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [ilist_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [ilist_pkg::STAT_W-1:0]     m_tuser
);

	logic                        in_acc, out_acc;
	logic [ilist_pkg::KIND_W-1:0] head_kind_q, tail_kind_q;
	logic [1:0]                   held_q;
	logic [ilist_pkg::CNT_W-1:0]  last_cnt_q;
	logic [ilist_pkg::CNT_W-1:0]  cnt;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign cnt     = m_tdata[36:32];

	// kinds of the words still owed a result, oldest at the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_kind_q <= ilist_pkg::KIND_READ;
			tail_kind_q <= ilist_pkg::KIND_READ;
			held_q      <= 2'd0;
			last_cnt_q  <= '0;
		end else begin
			if (out_acc) last_cnt_q <= cnt;
			case ({in_acc, out_acc})
				2'b10: begin
					if (held_q == 2'd0) head_kind_q <= s_tuser;
					else tail_kind_q <= s_tuser;
					held_q <= held_q + 2'd1;
				end
				2'b01: begin
					head_kind_q <= tail_kind_q;
					held_q      <= held_q - 2'd1;
				end
				2'b11: begin
					if (held_q == 2'd1) begin
						head_kind_q <= s_tuser;
					end else begin
						head_kind_q <= tail_kind_q;
						tail_kind_q <= s_tuser;
					end
				end
				default: ;
			endcase
		end
	end

	// one word in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input accepted twice in a row");

	a_err_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tuser != ilist_pkg::STAT_OK |-> cnt == last_cnt_q)
		else $error("failed operation changed the count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tuser == ilist_pkg::STAT_OK && head_kind_q == ilist_pkg::KIND_INSERT
		|-> cnt == last_cnt_q + 1'b1)
		else $error("insert did not add one entry");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tuser == ilist_pkg::STAT_OK && head_kind_q == ilist_pkg::KIND_REMOVE
		|-> cnt == last_cnt_q - 1'b1)
		else $error("remove did not drop one entry");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

endmodule

bind indexed_list_insert_remove_unit ilist_port_checker u_ilist_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ dv/ilist_checker.sv @@
`timescale 1ns / 100ps
// Checker for the indexed list unit: keeps its own copy of the list, predicts each result word
// and compares it with what the unit sends. Depends on ilist_pkg only.
module ilist_checker import ilist_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // position[4:0], value[36:5]
	input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // result_value[31:0], count[36:32]
	input  logic [STAT_W-1:0]     m_tuser,   // status[1:0]
	output int                    fail_count,
	output int                    pending,
	output int                    checked,
	output int                    index_hits,
	output int                    full_hits
);

	typedef struct packed {
		logic [VAL_W-1:0] value;
		status_t          status;
		logic [CNT_W-1:0] count;
	} list_result_t;

	logic [VAL_W-1:0] shadow_list [CAPACITY];
	int               shadow_len;
	list_result_t     expected_words [$];

	// Element width equals the result width here, so stored values come back unchanged.
	function automatic list_result_t apply_op(kind_t kind, int pos, logic [VAL_W-1:0] val);
		list_result_t r;
		r.value  = '0;
		r.status = STAT_OK;
		if (kind == KIND_INSERT) begin
			// position is checked before fullness
			if (pos > shadow_len)
				r.status = STAT_BAD_INDEX;
			else if (shadow_len >= CAPACITY)
				r.status = STAT_FULL;
			else begin
				for (int i = shadow_len; i > pos; i--)
					shadow_list[i] = shadow_list[i-1];
				shadow_list[pos] = val;
				shadow_len++;
			end
		end else if (pos >= shadow_len) begin
			r.status = STAT_BAD_INDEX;
		end else begin
			r.value = shadow_list[pos];
			if (kind == KIND_REMOVE) begin
				for (int i = pos + 1; i < shadow_len; i++)
					shadow_list[i-1] = shadow_list[i];
				shadow_list[shadow_len-1] = '0;
				shadow_len--;
			end else if (kind == KIND_WRITE) begin
				shadow_list[pos] = val;
			end
		end
		r.count = shadow_len[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		$display("%0t ns: %s got %0h, want %0h", $time, field, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		list_result_t want;
		if (!arst_n) begin
			foreach (shadow_list[i])
				shadow_list[i] = '0;
			shadow_len = 0;
			expected_words.delete();
			fail_count = 0;
			checked    = 0;
			index_hits = 0;
			full_hits  = 0;
		end else begin
			// compare first: the oldest expectation belongs to this result
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with nothing expected", m_tdata[VAL_W-1:0], '0);
				end else begin
					want = expected_words.pop_front();
					checked++;
					if (want.status == STAT_BAD_INDEX)
						index_hits++;
					if (want.status == STAT_FULL)
						full_hits++;
					if (m_tdata[VAL_W-1:0] !== want.value)
						report_mismatch("result_value", m_tdata[VAL_W-1:0], want.value);
					if (m_tuser !== want.status)
						report_mismatch("status", VAL_W'(m_tuser), VAL_W'(want.status));
					if (m_tdata[VAL_W+CNT_W-1:VAL_W] !== want.count)
						report_mismatch("count", VAL_W'(m_tdata[VAL_W+CNT_W-1:VAL_W]),
							VAL_W'(want.count));
				end
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(apply_op(kind_t'(s_tuser), int'(s_tdata[POS_W-1:0]),
					s_tdata[POS_W+VAL_W-1:POS_W]));
		end
		pending = expected_words.size();
	end

endmodule

@@ dv/tb_indexed_list_insert_remove_unit.sv @@
`timescale 1ns / 100ps
// Top of the indexed list unit testbench: clock, reset, directed and random words, verdict.
// Depends on ilist_pkg, the unit and ilist_checker.
module tb_indexed_list_insert_remove_unit;
	import ilist_pkg::*;

	localparam int CAP        = CAPACITY_DEF;
	localparam int PHASE_LEN  = 365;
	localparam int MAX_GAP    = 40;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;   // position[4:0], value[36:5]
	logic [KIND_W-1:0]     s_tuser  = '0;   // kind[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // result_value[31:0], count[36:32]
	logic [STAT_W-1:0]     m_tuser;         // status[1:0]

	int fail_count, pending, checked, index_hits, full_hits;
	int idle_pct  = 0;
	int stall_pct = 0;
	int fill      = 0;
	int kind_sent [4] = '{0, 0, 0, 0};

	indexed_list_insert_remove_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ilist_checker #(.CAPACITY(CAP)) scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.index_hits (index_hits),
		.full_hits  (full_hits)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one word, optionally after an idle gap, and hold it until accepted.
	task automatic send_word(kind_t kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, val, pos};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		kind_sent[kind]++;
		// track the list length only to steer the random positions
		case (kind)
			KIND_INSERT: if (int'(pos) <= fill && fill < CAP) fill++;
			KIND_REMOVE: if (int'(pos) < fill) fill--;
			default: ;
		endcase
	endtask

	// Hold off the sender until every expected result word has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int   r;
		bit   growing;
		kind_t kind;
		logic [POS_W-1:0] pos;

		growing = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, extremes of value and position, full list
		send_word(KIND_READ,   5'd0,  32'h0);
		send_word(KIND_REMOVE, 5'd0,  32'h0);
		send_word(KIND_WRITE,  5'd0,  32'h1234_5678);
		send_word(KIND_INSERT, 5'd1,  32'h0);
		send_word(KIND_INSERT, 5'd0,  32'h7fff_ffff);
		send_word(KIND_INSERT, 5'd0,  32'h8000_0000);
		send_word(KIND_INSERT, 5'd2,  32'h0);
		send_word(KIND_INSERT, 5'd1,  32'hffff_ffff);
		send_word(KIND_READ,   5'd3,  32'h0);
		send_word(KIND_WRITE,  5'd0,  32'haaaa_aaaa);
		repeat (12)
			send_word(KIND_INSERT, 5'd0, $urandom);
		send_word(KIND_INSERT, 5'd16, 32'h0);
		send_word(KIND_INSERT, 5'd31, 32'h0);
		send_word(KIND_READ,   5'd16, 32'h0);
		send_word(KIND_WRITE,  5'd15, 32'h5555_5555);
		send_word(KIND_REMOVE, 5'd0,  32'h0);
		send_word(KIND_REMOVE, 5'd14, 32'h0);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 83; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 83; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			for (int n = 0; n < PHASE_LEN; n++) begin
				// swing between filling and emptying, lingering at the ends
				if (fill == CAP && $urandom_range(99) < 30)
					growing = 1'b0;
				else if (fill == 0 && $urandom_range(99) < 30)
					growing = 1'b1;
				r = $urandom_range(99);
				if (r < (growing ? 45 : 15))
					kind = KIND_INSERT;
				else if (r < 60)
					kind = KIND_REMOVE;
				else if (r < 80)
					kind = KIND_READ;
				else
					kind = KIND_WRITE;
				if ($urandom_range(9) == 0)
					pos = POS_W'($urandom_range(31));
				else if (kind == KIND_INSERT)
					pos = POS_W'($urandom_range(fill));
				else
					pos = (fill == 0) ? 5'd0 : POS_W'($urandom_range(fill - 1));
				send_word(kind, pos, pick_value());
			end
			drain_results();
		end

		repeat (CAP + 4) @(posedge clk);
		$display("Sent %0d insert, %0d remove, %0d read, %0d write words over four pacing phases.",
			kind_sent[KIND_INSERT], kind_sent[KIND_REMOVE], kind_sent[KIND_READ],
			kind_sent[KIND_WRITE]);
		$display("Checked %0d result words: %0d bad index, %0d list full.",
			checked, index_hits, full_hits);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
